/* rtl/walu_pkg.sv */
// Shared types and constants for the 128-bit unsigned ALU.
// Used by walu_prep, walu_cell and wide_unsigned_alu_128.
package walu_pkg;

    localparam int unsigned LaneBits  = 64;
    localparam int unsigned WideBits  = 128;
    localparam int unsigned DigitBits = 32;
    localparam int unsigned NumDigits = WideBits / DigitBits;
    localparam int unsigned CountBits = 8;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_MUL  = 2'd1,
        OP_SHR  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Payload that travels down the chain alongside its valid bit.
    typedef struct packed {
        op_t                 op;
        logic [WideBits-1:0] a;
        logic [WideBits-1:0] b;
        logic [WideBits-1:0] acc;
    } item_t;

endpackage

/* rtl/walu_prep.sv */
// Front stage: registers the request and seeds the accumulator with the
// add or shift result, or zero for the other ops. Depends on walu_pkg.
module walu_prep (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic                                 in_valid,
    input  walu_pkg::op_t                        op,
    input  logic [walu_pkg::WideBits-1:0]        a,
    input  logic [walu_pkg::WideBits-1:0]        b,
    input  logic [walu_pkg::CountBits-1:0]       count,
    output logic                                 valid_out,
    output walu_pkg::item_t                      item_out
);

    logic                          valid_reg;
    walu_pkg::item_t               item_reg;
    walu_pkg::item_t               item_next;
    logic [walu_pkg::WideBits-1:0] shr_val;

    // count 128 and above clears; count[6:0] covers 0..127 exactly
    always_comb
    begin
        if (count[walu_pkg::CountBits-1])
            shr_val = '0;
        else
            shr_val = a >> count[walu_pkg::CountBits-2:0];
    end

    always_comb
    begin
        item_next.op = op;
        item_next.a  = a;
        item_next.b  = b;
        unique case (op)
            walu_pkg::OP_ADD: item_next.acc = a + b;
            walu_pkg::OP_SHR: item_next.acc = shr_val;
            default:          item_next.acc = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

/* rtl/walu_cell.sv */
// One multiply cell: partial products of A by digit DIGIT of B, then
// accumulate into the running product. Depends on walu_pkg.
module walu_cell #(
    parameter int unsigned DIGIT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            valid_in,
    input  walu_pkg::item_t item_in,
    output logic            valid_out,
    output walu_pkg::item_t item_out
);

    localparam int unsigned DW = walu_pkg::DigitBits;
    localparam int unsigned ND = walu_pkg::NumDigits;
    localparam int unsigned WB = walu_pkg::WideBits;

    logic                  s1_valid_reg;
    walu_pkg::item_t       s1_item_reg;
    logic [2*DW-1:0]       prod_reg [ND];
    logic                  s2_valid_reg;
    walu_pkg::item_t       s2_item_reg;
    walu_pkg::item_t       s2_item_next;
    logic [DW-1:0]         b_digit;
    logic [WB-1:0]         even_row;
    logic [WB-1:0]         odd_row;
    logic [WB-1:0]         row_sum;

    assign b_digit = item_in.b[DIGIT*DW +: DW];

    // stage 1: independent 32x32 products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= item_in;
            for (int i = 0; i < ND; i++)
                prod_reg[i] <= (2*DW)'(item_in.a[i*DW +: DW]) * (2*DW)'(b_digit);
        end
    end

    // even products do not overlap each other, nor do odd ones, so each row is a concatenation
    always_comb
    begin
        even_row = {prod_reg[2], prod_reg[0]};
        odd_row  = {prod_reg[3][DW-1:0], prod_reg[1], {DW{1'b0}}};
        row_sum  = even_row + odd_row;
        s2_item_next = s1_item_reg;
        if (s1_item_reg.op == walu_pkg::OP_MUL)
            s2_item_next.acc = s1_item_reg.acc + (row_sum << (DIGIT * DW));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_item_reg <= s2_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= valid_in;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign valid_out = s2_valid_reg;
    assign item_out  = s2_item_reg;

`ifndef ASSERT_OFF
    a_hold_s2: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s2_valid_reg))
        else $error("cell output valid moved while held");

    a_move_s2: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (s2_valid_reg == $past(s1_valid_reg)))
        else $error("cell lost or invented a request");

    a_pass_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_valid_reg && s1_item_reg.op != walu_pkg::OP_MUL)
        |=> (s2_item_reg.acc == $past(s1_item_reg.acc)))
        else $error("non-multiply result altered in cell");
`endif

endmodule

/* rtl/wide_unsigned_alu_128.sv */
// 128-bit unsigned ALU: add, multiply (low 128 bits), logical shift right.
// Pipeline: 1 prep stage plus 4 multiply cells of 2 stages each.
// Throughput: one request per cycle while the result is not stalled.
// The whole chain advances together and holds while the result is stalled.
// Reset (rst_n, async, active low) clears all valid bits; no clearing pass.
// Depends on walu_pkg, walu_prep, walu_cell.
module wide_unsigned_alu_128 (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic [walu_pkg::LaneBits-1:0]       a_low,
    input  logic [walu_pkg::LaneBits-1:0]       a_high,
    input  logic [walu_pkg::LaneBits-1:0]       b_low,
    input  logic [walu_pkg::LaneBits-1:0]       b_high,
    input  logic [walu_pkg::CountBits-1:0]      shift_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [walu_pkg::LaneBits-1:0]       result_low,
    output logic [walu_pkg::LaneBits-1:0]       result_high
);

    localparam int unsigned ND = walu_pkg::NumDigits;
    localparam int unsigned LB = walu_pkg::LaneBits;

    logic            adv;
    logic            chain_valid [ND+1];
    walu_pkg::item_t chain_item  [ND+1];

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    walu_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .op        (walu_pkg::op_t'(operation)),
        .a         ({a_high, a_low}),
        .b         ({b_high, b_low}),
        .count     (shift_count),
        .valid_out (chain_valid[0]),
        .item_out  (chain_item[0])
    );

    for (genvar k = 0; k < ND; k++)
    begin : g_cell
        walu_cell #(
            .DIGIT (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (chain_valid[k]),
            .item_in   (chain_item[k]),
            .valid_out (chain_valid[k+1]),
            .item_out  (chain_item[k+1])
        );
    end

    assign out_valid   = chain_valid[ND];
    assign result_low  = chain_item[ND].acc[LB-1:0];
    assign result_high = chain_item[ND].acc[2*LB-1:LB];

endmodule

/* tb/tb_wide_unsigned_alu_128.sv */
// Testbench for wide_unsigned_alu_128: directed and random requests with idle gaps,
// receiver back-pressure and a scoreboard fed by an in-bench 128-bit predictor.
// Depends on walu_pkg and the wide_unsigned_alu_128 RTL.
module tb_wide_unsigned_alu_128;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 30;
    localparam int MaxReports = 10;
    localparam int unsigned LB = walu_pkg::LaneBits;
    localparam int unsigned WB = walu_pkg::WideBits;
    localparam int unsigned CB = walu_pkg::CountBits;

    typedef struct {
        logic [LB-1:0] low;
        logic [LB-1:0] high;
    } wide_result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [1:0]    operation = walu_pkg::OP_ADD;
    logic [LB-1:0] a_low = '0;
    logic [LB-1:0] a_high = '0;
    logic [LB-1:0] b_low = '0;
    logic [LB-1:0] b_high = '0;
    logic [CB-1:0] shift_count = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [LB-1:0] result_low;
    logic [LB-1:0] result_high;

    wide_result_t pending_results[$];
    int           mismatches = 0;
    int           checked_count = 0;
    int           sent_count = 0;
    int           op_count[4] = '{0, 0, 0, 0};
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    // Long receiver hold-off: the test bumps hold_id, the stall process counts it out.
    int           hold_id = 0;
    int           hold_len = 0;
    int           hold_done = 0;
    int           hold_left = 0;

    wide_unsigned_alu_128 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .a_low       (a_low),
        .a_high      (a_high),
        .b_low       (b_low),
        .b_high      (b_high),
        .shift_count (shift_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_low  (result_low),
        .result_high (result_high)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // 128-bit wrap-around add, low half of the product, logical shift right.
    function automatic logic [WB-1:0] alu_result(input walu_pkg::op_t op,
                                                 input logic [WB-1:0] a,
                                                 input logic [WB-1:0] b,
                                                 input logic [CB-1:0] count);
        case (op)
            walu_pkg::OP_ADD: return a + b;
            walu_pkg::OP_MUL: return a * b;
            walu_pkg::OP_SHR: return (count >= WB) ? '0 : (a >> count);
            default:          return '0;
        endcase
    endfunction

    function automatic logic [WB-1:0] rand_operand();
        logic [WB-1:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            2:       v = {{(WB-1){1'b0}}, 1'b1} << $urandom_range(WB-1);
            3:       v = {{(WB-32){1'b0}}, v[31:0]};
            4:       v[WB-1:LB] = '0;
            5:       v[LB-1:0] = '1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input wide_result_t want);
        mismatches++;
        if (mismatches <= MaxReports)
            $display("Mismatch (%s) at cycle %0d: expected %h_%h, got %h_%h", what,
                     cycle_count, want.high, want.low, result_high, result_low);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_id != hold_done)
        begin
            hold_left = hold_len;
            hold_done = hold_id;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        wide_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                want.low = 'x;
                want.high = 'x;
                report_mismatch("unexpected result", want);
            end
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (result_low !== want.low)
                    report_mismatch("result_low", want);
                if (result_high !== want.high)
                    report_mismatch("result_high", want);
            end
        end
    end

    // Holds valid and payload until accepted; leaves valid high on return.
    task automatic send_request(input walu_pkg::op_t op, input logic [WB-1:0] a,
                                input logic [WB-1:0] b,
                                input logic [CB-1:0] count);
        logic [WB-1:0] r;
        wide_result_t  w;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        a_low       <= a[LB-1:0];
        a_high      <= a[WB-1:LB];
        b_low       <= b[LB-1:0];
        b_high      <= b[WB-1:LB];
        shift_count <= count;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = alu_result(op, a, b, count);
        w.low = r[LB-1:0];
        w.high = r[WB-1:LB];
        pending_results.push_back(w);
        sent_count++;
        op_count[op]++;
    endtask

    // Called right at an acceptance edge: drop valid, then wait for every result.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [WB-1:0] ones;
        logic [WB-1:0] lo_ones;
        logic [WB-1:0] pat;
        ones = '1;
        lo_ones = {{LB{1'b0}}, {LB{1'b1}}};
        pat = 128'h8123_4567_89ab_cdef_fedc_ba98_7654_3211;
        send_request(walu_pkg::OP_ADD, '0, '0, '0);
        send_request(walu_pkg::OP_ADD, ones, 128'd1, 8'd0);
        send_request(walu_pkg::OP_ADD, ones, ones, 8'hff);
        send_request(walu_pkg::OP_ADD, lo_ones, 128'd1, 8'd7);
        send_request(walu_pkg::OP_ADD, pat, ~pat, 8'd64);
        send_request(walu_pkg::OP_MUL, ones, ones, 8'd0);
        send_request(walu_pkg::OP_MUL, 128'd1 << 64, 128'd1 << 64, 8'd0);
        send_request(walu_pkg::OP_MUL, pat, '0, 8'hff);
        send_request(walu_pkg::OP_MUL, lo_ones, lo_ones, 8'd1);
        send_request(walu_pkg::OP_MUL, pat, 128'd1, 8'd128);
        send_request(walu_pkg::OP_MUL, pat, ones, 8'd3);
        // shift: zero count, inside the low lane, exactly one lane, past the width
        send_request(walu_pkg::OP_SHR, pat, ones, 8'd0);
        send_request(walu_pkg::OP_SHR, pat, '0, 8'd1);
        send_request(walu_pkg::OP_SHR, ones, pat, 8'd63);
        send_request(walu_pkg::OP_SHR, pat, pat, 8'd64);
        send_request(walu_pkg::OP_SHR, ones, '0, 8'd65);
        send_request(walu_pkg::OP_SHR, ones, '0, 8'd127);
        send_request(walu_pkg::OP_SHR, ones, ones, 8'd128);
        send_request(walu_pkg::OP_SHR, ones, ones, 8'd255);
        // unused selector returns zero whatever the operands
        send_request(walu_pkg::OP_NONE, ones, ones, 8'd5);
        send_request(walu_pkg::OP_NONE, pat, ~pat, 8'hff);
        wait_for_drain();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        int            n;
        walu_pkg::op_t op;
        logic [CB-1:0] sc;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            n = $urandom_range(99);
            op = (n < 30) ? walu_pkg::OP_ADD :
                 (n < 60) ? walu_pkg::OP_MUL :
                 (n < 90) ? walu_pkg::OP_SHR : walu_pkg::OP_NONE;
            sc = ($urandom_range(4) == 0) ? CB'($urandom_range(255))
                                          : CB'($urandom_range(WB-1));
            send_request(op, rand_operand(), rand_operand(), sc);
        end
        wait_for_drain();
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 60;
        hold_id++;
        repeat (50)
            send_request(walu_pkg::op_t'($urandom_range(3)), rand_operand(), rand_operand(),
                         CB'($urandom_range(255)));
        wait_for_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(340, 16, 53);
        test_random(340, 53, 16);
        test_random(340, 0, 0);
        test_backpressure();
        repeat (DrainCycles) @(posedge clk);
        $display("Sent %0d requests (add %0d, mul %0d, shr %0d, unused %0d), checked %0d",
                 sent_count, op_count[walu_pkg::OP_ADD], op_count[walu_pkg::OP_MUL],
                 op_count[walu_pkg::OP_SHR], op_count[walu_pkg::OP_NONE], checked_count);
        $display("Covered idle gaps on both sides, a long receiver hold-off, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/walu_pkg.sv
rtl/walu_prep.sv
rtl/walu_cell.sv
rtl/wide_unsigned_alu_128.sv
tb/tb_wide_unsigned_alu_128.sv
